// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the snfce_engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ASSERT_HOLD(label, cond, sig, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

// ----- rtl/snfce_pkg.sv -----
package snfce_pkg;

  localparam int unsigned AddrW = 26;
  localparam int unsigned LenW = 16;
  localparam int unsigned PageBytes = 256;
  localparam int unsigned PageW = $clog2(PageBytes);

  localparam logic [2:0] REQ_READ = 3'd0;
  localparam logic [2:0] REQ_PROG = 3'd1;
  localparam logic [2:0] REQ_SECT = 3'd2;
  localparam logic [2:0] REQ_BLOCK = 3'd3;
  localparam logic [2:0] REQ_CHIP = 3'd4;
  localparam logic [2:0] REQ_IDENT = 3'd5;
  localparam logic [2:0] REQ_TURN = 3'd6;

  localparam logic [2:0] ST_WORK = 3'd0;
  localparam logic [2:0] ST_DONE = 3'd1;
  localparam logic [2:0] ST_REJ = 3'd2;
  localparam logic [2:0] ST_LINK = 3'd3;
  localparam logic [2:0] ST_UNK = 3'd4;

  typedef struct packed {
    logic [2:0] req_type;
    logic [AddrW-1:0] address;
    logic [LenW-1:0] length;
    logic [7:0] data_byte;
    logic [7:0] miso_byte;
    logic link_error;
  } item_t;

  typedef struct packed {
    logic mosi_valid;
    logic [7:0] mosi_byte;
    logic frame_last;
    logic read_valid;
    logic [7:0] read_byte;
    logic [2:0] op_status;
  } result_t;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QW = $clog2(QDepth);

endpackage

// ----- rtl/spi_nor_flash_command_engine_unit.sv -----
// SPI NOR flash command sequencer.
// Input channel: push/full with req_type, address, length, data_byte,
// miso_byte and link_error. A request item starts an identify, read,
// program or erase operation; each later item of type link turn hands in
// the reply byte to the last sent byte and yields the next one.
// Result channel: empty/pop with mosi_valid, mosi_byte, frame_last,
// read_valid, read_byte and op_status; exactly one result per item.
// An item enters a four-entry input queue, the sequencer takes one per
// cycle while the output register is empty or popped, and writes its
// result into an output register.
// When pop stays low the output register holds, the sequencer stops and
// the queue fills; full rises once four items wait in it.
// Reset empties the queue, marks the output register empty and clears all sequencer state,
// including the stored device size, so requests are rejected until an
// identify succeeds.
module spi_nor_flash_command_engine_unit (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [2:0] req_type,
  input  logic [snfce_pkg::AddrW-1:0] address,
  input  logic [snfce_pkg::LenW-1:0] length,
  input  logic [7:0] data_byte,
  input  logic [7:0] miso_byte,
  input  logic link_error,
  output logic empty,
  input  logic pop,
  output logic mosi_valid,
  output logic [7:0] mosi_byte,
  output logic frame_last,
  output logic read_valid,
  output logic [7:0] read_byte,
  output logic [2:0] op_status
);
  import snfce_pkg::*;

  item_t in_item, q_item;
  result_t res;
  logic q_empty, take;

  assign in_item = '{req_type: req_type, address: address, length: length,
                     data_byte: data_byte, miso_byte: miso_byte,
                     link_error: link_error};

  snfce_queue u_queue (
    .clk(clk), .rst(rst), .wr(push), .wdata(in_item), .full(full),
    .rd(take), .rdata(q_item), .empty(q_empty)
  );

  snfce_engine u_engine (
    .clk(clk), .rst(rst), .item(q_item), .item_valid(!q_empty),
    .item_take(take), .res(res), .res_empty(empty), .res_pop(pop)
  );

  assign mosi_valid = res.mosi_valid;
  assign mosi_byte = res.mosi_byte;
  assign frame_last = res.frame_last;
  assign read_valid = res.read_valid;
  assign read_byte = res.read_byte;
  assign op_status = res.op_status;
endmodule

// ----- rtl/snfce_queue.sv -----
module snfce_queue (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  snfce_pkg::item_t wdata,
  output logic full,
  input  logic rd,
  output snfce_pkg::item_t rdata,
  output logic empty
);
  import snfce_pkg::*;

  item_t mem [QDepth];
  logic [QW-1:0] wp;
  logic [QW-1:0] rp;
  logic [QW:0] cnt;

  assign full = (cnt == (QW+1)'(QDepth));
  assign empty = (cnt == '0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr && !full) wp <= wp + 1'b1;
      if (rd && !empty) rp <= rp + 1'b1;
      cnt <= cnt + (QW+1)'(wr && !full) - (QW+1)'(rd && !empty);
    end
  end
endmodule

// ----- rtl/snfce_engine.sv -----
`include "assert_macros.svh"
module snfce_engine (
  input  logic clk,
  input  logic rst,
  input  snfce_pkg::item_t item,
  input  logic item_valid,
  output logic item_take,
  output snfce_pkg::result_t res,
  output logic res_empty,
  input  logic res_pop
);
  import snfce_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_WREN = 3'd1;
  localparam logic [2:0] PH_CMD = 3'd2;
  localparam logic [2:0] PH_POLL = 3'd3;
  localparam logic [2:0] PH_ID = 3'd4;
  localparam logic [2:0] PH_UID = 3'd5;

  logic [2:0] phase, phase_next;
  logic [2:0] op, op_next;
  logic [16:0] idx, idx_next;
  logic [AddrW-1:0] taddr, taddr_next;
  logic [LenW-1:0] rem, rem_next;
  logic [26:0] dsize, dsize_next;
  logic [7:0] manuf, manuf_next;
  result_t r;
  logic full_r;

  assign item_take = item_valid && (res_empty || res_pop);

  function automatic logic [17:0] flen(input logic [2:0] ph, input logic [2:0] o,
                                       input logic [LenW-1:0] rc);
    logic [17:0] v;
    v = 18'd1;
    unique case (ph)
      PH_POLL: v = 18'd2;
      PH_ID: v = 18'd6;
      PH_UID: v = 18'd13;
      PH_CMD: begin
        if (o == REQ_READ) v = 18'd5 + 18'(rc);
        else if (o == REQ_PROG) v = 18'd4 + 18'(rc);
        else if (o == REQ_SECT || o == REQ_BLOCK) v = 18'd4;
      end
      default: v = 18'd1;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] bat(input logic [2:0] ph, input logic [2:0] o,
      input logic [16:0] i, input logic [AddrW-1:0] a, input logic [7:0] d);
    logic [7:0] v;
    v = 8'h00;
    unique case (ph)
      PH_WREN: v = 8'h06;
      PH_POLL: v = (i == 17'd0) ? 8'h05 : 8'h00;
      PH_ID: v = (i == 17'd0) ? 8'h90 : 8'h00;
      PH_UID: v = (i == 17'd0) ? 8'h4B : 8'h00;
      PH_CMD: begin
        if (i == 17'd0) begin
          case (o)
            REQ_READ: v = 8'h0B;
            REQ_PROG: v = 8'h02;
            REQ_SECT: v = 8'h20;
            REQ_BLOCK: v = 8'hD8;
            REQ_CHIP: v = 8'hC7;
            default: v = 8'h00;
          endcase
        end else if (i == 17'd1) v = a[23:16];
        else if (i == 17'd2) v = a[15:8];
        else if (i == 17'd3) v = a[7:0];
        else if (o == REQ_PROG) v = d;
      end
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  logic [AddrW:0] asum;
  logic [PageW:0] room;
  logic [LenW-1:0] clen;
  logic [17:0] fl;
  logic busy;
  logic rv;
  logic [2:0] fph;

  always_comb begin
    phase_next = phase;
    op_next = op;
    idx_next = idx;
    taddr_next = taddr;
    rem_next = rem;
    dsize_next = dsize;
    manuf_next = manuf;
    r = '0;
    asum = (AddrW+1)'(item.address) + (AddrW+1)'(item.length);
    room = (PageW+1)'(PageBytes) - (PageW+1)'(item.address[PageW-1:0]);
    clen = item.length;
    fl = flen(phase, op, rem);
    busy = 1'b0;
    rv = 1'b0;
    fph = PH_IDLE;
    if (phase == PH_IDLE) begin
      if (item.req_type > REQ_IDENT) begin
        r = '0;
      end else if ((item.req_type <= REQ_PROG && (item.length == '0 ||
                  27'(asum) > dsize)) ||
                  ((item.req_type == REQ_SECT || item.req_type == REQ_BLOCK) &&
                  27'(item.address) >= dsize) ||
                  (item.req_type == REQ_CHIP && dsize == '0)) begin
        r.op_status = ST_REJ;
      end else begin
        if (item.req_type == REQ_PROG && 17'(item.length) > 17'(room))
          clen = LenW'(room);
        op_next = item.req_type;
        taddr_next = item.address;
        if (item.req_type == REQ_SECT) taddr_next[11:0] = '0;
        if (item.req_type == REQ_BLOCK) taddr_next[15:0] = '0;
        rem_next = (item.req_type <= REQ_PROG) ? clen : '0;
        fph = (item.req_type == REQ_READ) ? PH_CMD :
              (item.req_type == REQ_IDENT) ? PH_ID : PH_WREN;
        phase_next = fph;
        idx_next = '0;
        r.mosi_valid = 1'b1;
        r.mosi_byte = bat(fph, item.req_type, 17'd0, taddr_next, item.data_byte);
        r.frame_last = (flen(fph, item.req_type, rem_next) == 18'd1);
      end
    end else if (item.req_type != REQ_TURN) begin
      r = '0;
    end else if (item.link_error) begin
      phase_next = PH_IDLE;
      idx_next = '0;
      r.op_status = ST_LINK;
    end else begin
      if (phase == PH_ID && idx == 17'd4) manuf_next = item.miso_byte;
      rv = (phase == PH_UID || (phase == PH_CMD && op == REQ_READ)) && idx >= 17'd5;
      r.read_valid = rv;
      r.read_byte = rv ? item.miso_byte : 8'h00;
      busy = (phase == PH_POLL && idx == 17'd1) && item.miso_byte[0];
      if (18'(idx) + 18'd1 < fl) begin
        idx_next = idx + 17'd1;
        r.mosi_valid = 1'b1;
        r.mosi_byte = bat(phase, op, idx + 17'd1, taddr, item.data_byte);
        r.frame_last = (18'(idx) + 18'd2 == fl);
      end else begin
        fph = PH_IDLE;
        unique case (phase)
          PH_WREN: fph = PH_CMD;
          PH_CMD: fph = (op == REQ_READ) ? PH_IDLE : PH_POLL;
          PH_POLL: fph = busy ? PH_POLL : PH_IDLE;
          PH_ID: begin
            if (manuf_next != 8'hEF || item.miso_byte < 8'h14 ||
                item.miso_byte > 8'h19) begin
              fph = PH_IDLE;
              r.op_status = ST_UNK;
            end else begin
              fph = PH_UID;
              dsize_next = 27'h200000 << (item.miso_byte[2:0] - 3'd4);
            end
          end
          default: fph = PH_IDLE;
        endcase
        phase_next = fph;
        idx_next = '0;
        if (fph == PH_IDLE) begin
          if (r.op_status != ST_UNK) r.op_status = ST_DONE;
        end else begin
          r.mosi_valid = 1'b1;
          r.mosi_byte = bat(fph, op, 17'd0, taddr, item.data_byte);
          r.frame_last = (flen(fph, op, rem) == 18'd1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      op <= '0;
      idx <= '0;
      taddr <= '0;
      rem <= '0;
      dsize <= '0;
      manuf <= '0;
      full_r <= 1'b0;
    end else begin
      if (item_take) begin
        phase <= phase_next;
        op <= op_next;
        idx <= idx_next;
        taddr <= taddr_next;
        rem <= rem_next;
        dsize <= dsize_next;
        manuf <= manuf_next;
        full_r <= 1'b1;
      end else if (res_pop) begin
        full_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) res <= r;
  end

  assign res_empty = !full_r;

  `ASSERT_CLK(a_idle_idx, (phase == PH_IDLE) |-> (idx == '0), "index not clear in idle")
  `ASSERT_CLK(a_take_fills, item_take |=> !res_empty, "result not held after take")
  `ASSERT_HOLD(a_stall_hold, !res_empty && !res_pop, res, "result changed")
endmodule
